FILE: src/srb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_pkg: shared types and constants of the stream byte reassembler
// Field widths, window default, and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package srb_pkg;

	localparam int WINDOW_DEF = 64;

	localparam int IDX_W  = 64;
	localparam int BYTE_W = 8;
	localparam int ROOM_W = 7;
	localparam int PEND_W = 7;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // latch an input word
		logic apply;      // end marker, window trim, byte insert
		logic scan;       // release one head slot
		logic finish;     // close check, latch pending count
		logic emit_rd;    // read the next released byte
		logic emit_ld;    // load a released byte into the output register
		logic emit_empty; // load the no-release result
	} srb_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_go;   // head slot valid and inside window
		logic run_zero;  // nothing released this item
		logic emit_last; // byte being loaded is the last of the run
		logic out_free;  // output register can take a word this cycle
	} srb_stat_t;

endpackage
`default_nettype wire

FILE: src/srb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: src/srb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_ctrl: reassembler controller
// Sequences accept, apply, head scan, count settle, finish and emit.
// ----------------------------------------------------------------------------
module srb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire srb_pkg::srb_stat_t stat,
	output srb_pkg::srb_cmd_t      cmd
);

	import srb_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_APPLY = 4'd1;
	localparam logic [3:0] ST_SCAN  = 4'd2;
	localparam logic [3:0] ST_CNT   = 4'd3;
	localparam logic [3:0] ST_FIN   = 4'd4;
	localparam logic [3:0] ST_RD    = 4'd5;
	localparam logic [3:0] ST_LD    = 4'd6;
	localparam logic [3:0] ST_ZERO  = 4'd7;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_go) begin
					cmd.scan = 1'b1;
				end else begin
					state_d = ST_CNT;
				end
			end
			ST_CNT: begin
				// popcount tree settles on the final valid map
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = stat.run_zero ? ST_ZERO : ST_RD;
			end
			ST_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_LD;
			end
			ST_LD: begin
				if (stat.out_free) begin
					cmd.emit_ld = 1'b1;
					state_d     = stat.emit_last ? ST_IDLE : ST_RD;
				end
			end
			ST_ZERO: begin
				if (stat.out_free) begin
					cmd.emit_empty = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: src/srb_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_dpath: reassembler datapath
// Circular slot window with valid map, byte RAM, stream pointers, popcount
// tree and the output register.
// ----------------------------------------------------------------------------
module srb_dpath #(
	parameter int WINDOW = srb_pkg::WINDOW_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire srb_pkg::srb_cmd_t          cmd,
	output srb_pkg::srb_stat_t              stat,
	input  wire logic [srb_pkg::IDX_W-1:0]  in_index,
	input  wire logic [srb_pkg::BYTE_W-1:0] in_byte,
	input  wire logic                       in_has,
	input  wire logic                       in_last,
	input  wire logic [srb_pkg::ROOM_W-1:0] in_room,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output logic [srb_pkg::BYTE_W-1:0]      out_byte,
	output logic                            out_bvalid,
	output logic                            out_last,
	output logic                            out_closed,
	output logic [srb_pkg::PEND_W-1:0]      out_pend
);

	import srb_pkg::*;

	localparam int AW = $clog2(WINDOW);
	localparam int CW = $clog2(WINDOW + 1);
	localparam int MW = (CW > ROOM_W) ? CW : ROOM_W;
	localparam int NG = (WINDOW + 7) / 8;

	// captured input word
	logic [IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0] byte_q;
	logic              has_q;
	logic              last_q;
	logic [ROOM_W-1:0] room_q;

	// stream state
	logic [WINDOW-1:0] valid_q;
	logic [AW-1:0]     head_q;
	logic [IDX_W-1:0]  ne_q;
	logic              end_known_q;
	logic [IDX_W-1:0]  end_pos_q;
	logic              closed_q;

	// per-item working registers
	logic [CW-1:0]     win_q;
	logic [CW-1:0]     run_q;
	logic [CW-1:0]     k_q;
	logic [AW-1:0]     rd_ptr_q;
	logic              close_q;
	logic [PEND_W-1:0] pend_q;

	// popcount tree
	logic [3:0]    grp_q [NG];
	logic [CW-1:0] cnt_q;

	// output register
	logic              ov_q;
	logic [BYTE_W-1:0] ob_q;
	logic              obv_q;
	logic              ol_q;
	logic              oc_q;
	logic [PEND_W-1:0] op_q;

	logic [CW-1:0]      win_c;
	logic [IDX_W-1:0]   diff_c;
	logic               ins_c;
	logic [AW-1:0]      ins_addr_c;
	logic [AW:0]        ins_sum_c;
	logic [WINDOW-1:0]  keep_c;
	logic [WINDOW-1:0]  set_c;
	logic [AW-1:0]      head_inc_c;
	logic [AW-1:0]      rd_inc_c;
	logic [BYTE_W-1:0]  rd_data;
	logic               close_c;
	logic [CW-1:0]      cnt_c;

	// window = min(room, WINDOW)
	always_comb begin
		if (MW'(room_q) < MW'(WINDOW)) begin
			win_c = CW'(room_q);
		end else begin
			win_c = CW'(WINDOW);
		end
	end

	assign diff_c     = idx_q - ne_q;
	assign ins_c      = has_q && (idx_q >= ne_q) && (diff_c < IDX_W'(win_c));
	assign ins_sum_c  = {1'b0, head_q} + {1'b0, diff_c[AW-1:0]};
	assign ins_addr_c = (ins_sum_c >= (AW+1)'(WINDOW)) ?
		AW'(ins_sum_c - (AW+1)'(WINDOW)) : ins_sum_c[AW-1:0];

	// trim slots at or beyond the window, mark the inserted slot
	always_comb begin
		int rel;
		for (int i = 0; i < WINDOW; i++) begin
			if (i >= int'(head_q)) begin
				rel = i - int'(head_q);
			end else begin
				rel = i + WINDOW - int'(head_q);
			end
			keep_c[i] = (rel < int'(win_c));
			set_c[i]  = ins_c && (ins_addr_c == AW'(i));
		end
	end

	assign head_inc_c = (head_q == AW'(WINDOW - 1)) ? '0 : head_q + 1'b1;
	assign rd_inc_c   = (rd_ptr_q == AW'(WINDOW - 1)) ? '0 : rd_ptr_q + 1'b1;

	assign close_c = end_known_q && (end_pos_q == ne_q) && !closed_q;

	always_comb begin
		cnt_c = '0;
		for (int g = 0; g < NG; g++) begin
			cnt_c = cnt_c + CW'(grp_q[g]);
		end
	end

	assign stat.scan_go   = (run_q < win_q) && valid_q[head_q];
	assign stat.run_zero  = (run_q == '0);
	assign stat.emit_last = ((k_q + CW'(1)) == run_q);
	assign stat.out_free  = !ov_q || out_ready;

	srb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(WINDOW)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.apply && ins_c),
		.wr_addr(ins_addr_c),
		.wr_data(byte_q),
		.rd_en  (cmd.emit_rd),
		.rd_addr(rd_ptr_q),
		.rd_data(rd_data)
	);

	// input capture and per-item registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q  <= in_index;
			byte_q <= in_byte;
			has_q  <= in_has;
			last_q <= in_last;
			room_q <= in_room;
		end
		if (cmd.apply) begin
			win_q    <= win_c;
			run_q    <= '0;
			rd_ptr_q <= head_q;
		end
		if (cmd.scan) begin
			run_q <= run_q + CW'(1);
		end
		if (cmd.finish) begin
			close_q <= close_c;
			pend_q  <= PEND_W'(cnt_q);
			k_q     <= '0;
		end
		if (cmd.emit_ld) begin
			k_q      <= k_q + CW'(1);
			rd_ptr_q <= rd_inc_c;
		end
	end

	// popcount over the valid map, two registered levels
	always_ff @(posedge clk) begin
		for (int g = 0; g < NG; g++) begin
			logic [3:0] acc;
			acc = '0;
			for (int b = 0; b < 8; b++) begin
				if (g * 8 + b < WINDOW) begin
					acc = acc + 4'(valid_q[g * 8 + b]);
				end
			end
			grp_q[g] <= acc;
		end
		cnt_q <= cnt_c;
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			head_q      <= '0;
			ne_q        <= '0;
			end_known_q <= 1'b0;
			end_pos_q   <= '0;
			closed_q    <= 1'b0;
		end else begin
			if (cmd.apply) begin
				valid_q <= (valid_q & keep_c) | set_c;
				if (last_q) begin
					end_known_q <= 1'b1;
					end_pos_q   <= idx_q + IDX_W'(has_q);
				end
			end
			if (cmd.scan) begin
				valid_q[head_q] <= 1'b0;
				head_q          <= head_inc_c;
				ne_q            <= ne_q + IDX_W'(1);
			end
			if (cmd.finish && close_c) begin
				closed_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit_ld || cmd.emit_empty) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			ob_q  <= rd_data;
			obv_q <= 1'b1;
			ol_q  <= stat.emit_last;
			oc_q  <= stat.emit_last && close_q;
			op_q  <= pend_q;
		end else if (cmd.emit_empty) begin
			ob_q  <= '0;
			obv_q <= 1'b0;
			ol_q  <= 1'b1;
			oc_q  <= close_q;
			op_q  <= pend_q;
		end
	end

	assign out_valid  = ov_q;
	assign out_byte   = ob_q;
	assign out_bvalid = obv_q;
	assign out_last   = ol_q;
	assign out_closed = oc_q;
	assign out_pend   = op_q;

endmodule
`default_nettype wire

FILE: src/stream_byte_reassembler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stream_byte_reassembler_unit: out-of-order stream byte reassembler
// Holds bytes tagged with absolute stream indexes in a window of WINDOW
// slots and releases the contiguous run at the head in order.
// ----------------------------------------------------------------------------
// Usage: each input word carries one byte (or a bare end marker) with its
// absolute 64-bit stream index and the downstream room. The usable window
// is min(room, WINDOW) slots from the next expected index; bytes outside it
// are dropped, slots beyond it are discarded. When the head slot fills, the
// whole contiguous run is sent out as one word per byte, tlast on the final
// word of the item; an item that releases nothing gives a single word with
// tuser low. Every word carries the held byte count after the item, and the
// word on which the stream becomes complete carries the close flag, once.
// Timing: one item at a time. After acceptance the item is applied, the
// head slots are walked byte by byte, the held-count popcount tree settles,
// the finish step latches the count, and each byte is read from the byte RAM
// (one read port, registered read) and then loaded into the output register;
// a load waits while that register holds an untaken word. The output
// register lets the next item be accepted while the last word waits for
// tready. Reset clears the valid map at once; the byte RAM needs no clearing.
// ----------------------------------------------------------------------------
module stream_byte_reassembler_unit #(
	parameter int WINDOW = srb_pkg::WINDOW_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input words
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,  // stream_index, data_byte, room, zero pad
	input  wire logic        s_axis_tuser,  // has_byte
	input  wire logic        s_axis_tlast,  // is_last
	// result words
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // out_byte, stream_closed, pending_count
	output logic             m_axis_tuser,  // byte_valid
	output logic             m_axis_tlast   // run_last
);

	import srb_pkg::*;

	srb_cmd_t  cmd;
	srb_stat_t stat;

	logic [BYTE_W-1:0] out_byte;
	logic              out_closed;
	logic [PEND_W-1:0] out_pend;

	srb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	srb_dpath #(
		.WINDOW(WINDOW)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_index  (s_axis_tdata[63:0]),
		.in_byte   (s_axis_tdata[71:64]),
		.in_has    (s_axis_tuser),
		.in_last   (s_axis_tlast),
		.in_room   (s_axis_tdata[78:72]),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_byte  (out_byte),
		.out_bvalid(m_axis_tuser),
		.out_last  (m_axis_tlast),
		.out_closed(out_closed),
		.out_pend  (out_pend)
	);

	assign m_axis_tdata = {out_pend, out_closed, out_byte};

endmodule
`default_nettype wire
